FILE: hw/rtl/tci_pkg.sv
// ============================================================================
// tci_pkg
// shared constants and helpers for the trilinear cube interpolator
// ============================================================================
package tci_pkg;

    localparam int SIZE_I = 16;
    localparam int SIZE_J = 16;
    localparam int SIZE_K = 16;

    localparam int IDX_W      = 4;
    localparam int SAMPLE_W   = 16;
    localparam int FRAC_W     = 17;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_BANKS  = 8;
    localparam int BANK_SEL_W = 3;
    localparam int BANK_AW    = 3 * (IDX_W - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;

    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 16;

    // blend widths along each axis
    localparam int PROD_I_W = SAMPLE_W + 1 + FRAC_W + 1;
    localparam int LIN_I_W  = SAMPLE_W + FRAC_BITS;
    localparam int PROD_J_W = LIN_I_W + 1 + FRAC_W + 1;
    localparam int LIN_J_W  = SAMPLE_W + 2 * FRAC_BITS;
    localparam int SPLIT_W  = 24;
    localparam int HI_W     = LIN_J_W + 1 - SPLIT_W;
    localparam int PLO_W    = SPLIT_W + FRAC_W;
    localparam int PHI_W    = HI_W + FRAC_W + 1;
    localparam int TOT_W    = SAMPLE_W + 3 * FRAC_BITS + 2;

    localparam logic [FRAC_W-1:0] ONE_Q16 = FRAC_W'(1 << FRAC_BITS);
    localparam logic signed [TOT_W-1:0] ROUND_HALF = TOT_W'(1) << (3 * FRAC_BITS - 1);

    localparam logic [IDX_W-1:0] MAX_BASE_I = IDX_W'(SIZE_I - 2);
    localparam logic [IDX_W-1:0] MAX_BASE_J = IDX_W'(SIZE_J - 2);
    localparam logic [IDX_W-1:0] MAX_BASE_K = IDX_W'(SIZE_K - 2);

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    function automatic logic [FRAC_W-1:0] sat_frac(input logic [FRAC_W-1:0] f);
        return (f > ONE_Q16) ? ONE_Q16 : f;
    endfunction

endpackage

FILE: hw/rtl/tci_ram.sv
// ============================================================================
// tci_ram
// simple dual-port ram, one write port, one registered read port
// ============================================================================
module tci_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/trilinear_cube_interpolator.sv
// ============================================================================
// trilinear_cube_interpolator
// 16x16x16 cube of signed samples in eight parity banks; writes store one
// sample, queries blend the eight corners along i, j, k and round half up
// ============================================================================
//  channel  | ports          | tuser        | tdata
//  ---------+----------------+--------------+----------------------------------
//  input    | s_tvalid/ready | mode         | idx_i idx_j idx_k sample_in
//           |                |              | frac_i frac_j frac_k
//  result   | m_tvalid/ready | index_error  | interp_value
//
//  one transaction per cycle unless the result stalls; a query result
//  passes through the bank read, one multiply stage per axis and a final sum
//  the eight corners sit in separate banks, so all are read in the same cycle
//  writes produce no result; the cube content is undefined after reset
//  aresetn clears only the pipeline valid bits
//  a stalled result holds the whole pipeline and s_tready
// ============================================================================
module trilinear_cube_interpolator
    import tci_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // idx_i, idx_j, idx_k, sample_in, frac_i, frac_j, frac_k, zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    // mode
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // interp_value
    output logic [M_DATA_W-1:0] m_tdata,
    // index_error
    output logic                m_tuser
);

    // input fields
    logic                      mode;
    logic [IDX_W-1:0]          idx_i, idx_j, idx_k;
    logic [SAMPLE_W-1:0]       sample_in;
    logic [FRAC_W-1:0]         frac_i, frac_j, frac_k;

    assign mode      = s_tuser;
    assign idx_i     = s_tdata[3:0];
    assign idx_j     = s_tdata[7:4];
    assign idx_k     = s_tdata[11:8];
    assign sample_in = s_tdata[27:12];
    assign frac_i    = s_tdata[44:28];
    assign frac_j    = s_tdata[61:45];
    assign frac_k    = s_tdata[78:62];

    logic adv;
    logic s_accept;

    // bank ports
    logic [NUM_BANKS-1:0]  bank_we;
    logic [BANK_AW-1:0]    wr_addr;
    logic [BANK_AW-1:0]    rd_addr [NUM_BANKS];
    logic [SAMPLE_W-1:0]   rd_data [NUM_BANKS];

    // pipeline registers
    logic                          v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic                          err1_reg, err2_reg, err3_reg, err4_reg, out_err_reg;
    logic [BANK_SEL_W-1:0]         par1_reg;
    logic [FRAC_W-1:0]             ri1_reg, rj1_reg, rk1_reg, rj2_reg, rk2_reg, rk3_reg;
    logic signed [LIN_I_W-1:0]     lin_i_reg [4];
    logic signed [LIN_J_W-1:0]     lin_j_reg [2];
    logic signed [LIN_J_W-1:0]     base_reg;
    logic [PLO_W-1:0]              plo_reg;
    logic signed [PHI_W-1:0]       phi_reg;
    logic [M_DATA_W-1:0]           out_data_reg;

    logic                          v1_next, err1_next;
    logic [BANK_SEL_W-1:0]         par1_next;
    logic [FRAC_W-1:0]             ri1_next, rj1_next, rk1_next;
    logic signed [LIN_I_W-1:0]     lin_i_next [4];
    logic signed [LIN_J_W-1:0]     lin_j_next [2];
    logic [PLO_W-1:0]              plo_next;
    logic signed [PHI_W-1:0]       phi_next;
    logic [M_DATA_W-1:0]           out_data_next;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign s_accept = s_tvalid && adv;

    // write path and corner addresses
    always_comb begin
        logic [IDX_W:0] ci, cj, ck;
        wr_addr = {idx_i[IDX_W-1:1], idx_j[IDX_W-1:1], idx_k[IDX_W-1:1]};
        for (int b = 0; b < NUM_BANKS; b++) begin
            bank_we[b] = s_accept && (mode == MODE_WRITE) &&
                         ({idx_i[0], idx_j[0], idx_k[0]} == BANK_SEL_W'(b));
            ci = (IDX_W+1)'(idx_i) + (IDX_W+1)'(b[2] ^ idx_i[0]);
            cj = (IDX_W+1)'(idx_j) + (IDX_W+1)'(b[1] ^ idx_j[0]);
            ck = (IDX_W+1)'(idx_k) + (IDX_W+1)'(b[0] ^ idx_k[0]);
            rd_addr[b] = {ci[IDX_W-1:1], cj[IDX_W-1:1], ck[IDX_W-1:1]};
        end
    end

    for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
        tci_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .aclk    (aclk),
            .wr_en   (bank_we[g]),
            .wr_addr (wr_addr),
            .wr_data (sample_in),
            .rd_en   (adv),
            .rd_addr (rd_addr[g]),
            .rd_data (rd_data[g])
        );
    end

    // stage 0: query decode
    always_comb begin
        v1_next   = s_accept && (mode == MODE_QUERY);
        err1_next = (idx_i > MAX_BASE_I) || (idx_j > MAX_BASE_J) || (idx_k > MAX_BASE_K);
        par1_next = {idx_i[0], idx_j[0], idx_k[0]};
        ri1_next  = sat_frac(frac_i);
        rj1_next  = sat_frac(frac_j);
        rk1_next  = sat_frac(frac_k);
    end

    // stage 1: blend along i
    always_comb begin
        logic signed [SAMPLE_W-1:0] corner [NUM_BANKS];
        logic signed [SAMPLE_W:0]   diff_i;
        logic signed [PROD_I_W-1:0] prod_i;
        for (int c = 0; c < NUM_BANKS; c++) begin
            corner[c] = $signed(rd_data[BANK_SEL_W'(c) ^ par1_reg]);
        end
        for (int m = 0; m < 4; m++) begin
            diff_i = (SAMPLE_W+1)'(corner[m+4]) - (SAMPLE_W+1)'(corner[m]);
            prod_i = PROD_I_W'(diff_i) * PROD_I_W'($signed({1'b0, ri1_reg}));
            lin_i_next[m] = LIN_I_W'((PROD_I_W'(corner[m]) <<< FRAC_BITS) + prod_i);
        end
    end

    // stage 2: blend along j
    always_comb begin
        logic signed [LIN_I_W:0]    diff_j;
        logic signed [PROD_J_W-1:0] prod_j;
        for (int n = 0; n < 2; n++) begin
            diff_j = (LIN_I_W+1)'(lin_i_reg[n+2]) - (LIN_I_W+1)'(lin_i_reg[n]);
            prod_j = PROD_J_W'(diff_j) * PROD_J_W'($signed({1'b0, rj2_reg}));
            lin_j_next[n] = LIN_J_W'((PROD_J_W'(lin_i_reg[n]) <<< FRAC_BITS) + prod_j);
        end
    end

    // stage 3: blend along k, split multiply
    always_comb begin
        logic signed [LIN_J_W:0] diff_k;
        diff_k   = (LIN_J_W+1)'(lin_j_reg[1]) - (LIN_J_W+1)'(lin_j_reg[0]);
        plo_next = PLO_W'(diff_k[SPLIT_W-1:0]) * PLO_W'(rk3_reg);
        phi_next = PHI_W'($signed(diff_k[LIN_J_W:SPLIT_W])) *
                   PHI_W'($signed({1'b0, rk3_reg}));
    end

    // stage 4: sum partial products and round half up
    always_comb begin
        logic signed [TOT_W-1:0] base_ext, hi_ext, lo_ext, total;
        base_ext = TOT_W'(base_reg);
        hi_ext   = TOT_W'(phi_reg);
        lo_ext   = $signed({{(TOT_W-PLO_W){1'b0}}, plo_reg});
        total    = (base_ext <<< FRAC_BITS) + (hi_ext <<< SPLIT_W) + lo_ext + ROUND_HALF;
        out_data_next = err4_reg ? '0
                                 : total[SAMPLE_W+3*FRAC_BITS-1:3*FRAC_BITS];
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg        <= v1_next;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            err1_reg     <= err1_next;
            par1_reg     <= par1_next;
            ri1_reg      <= ri1_next;
            rj1_reg      <= rj1_next;
            rk1_reg      <= rk1_next;
            err2_reg     <= err1_reg;
            lin_i_reg    <= lin_i_next;
            rj2_reg      <= rj1_reg;
            rk2_reg      <= rk1_reg;
            err3_reg     <= err2_reg;
            lin_j_reg    <= lin_j_next;
            rk3_reg      <= rk2_reg;
            err4_reg     <= err3_reg;
            base_reg     <= lin_j_reg[0];
            plo_reg      <= plo_next;
            phi_reg      <= phi_next;
            out_err_reg  <= err4_reg;
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

`ifndef SYNTHESIS
    a_err_gives_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("index error result carries nonzero value");

    a_one_bank_write : assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(bank_we))
        else $error("more than one bank written");

    a_write_no_result : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (mode == MODE_WRITE)) |=> !v1_reg)
        else $error("write transaction entered the result pipeline");

    a_stall_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> ($stable(v4_reg) && $stable(out_data_reg)))
        else $error("pipeline moved during stall");
`endif

endmodule
